[rtl/bfpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants for the best-fit pool allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam int unsigned TableEntriesDefault = 64;
    localparam int unsigned AddrBits            = 32;
    localparam logic [31:0] PoolBytesReset      = 32'd1048576;
    localparam logic [15:0] SplitThreshReset    = 16'd256;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusNoFit   = 2'd1;
    localparam logic [1:0] StatusBadFree = 2'd2;

    localparam logic ActionAlloc = 1'b0;
    localparam logic ActionFree  = 1'b1;

    localparam logic [1:0] RegPoolBytes  = 2'd0;
    localparam logic [1:0] RegSplitThres = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT,
        ST_SPLIT,
        ST_OUT,
        ST_CLEAR
    } state_t;

endpackage

[rtl/bfpa_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_table
// Block table memory: start, size and flags, one read and one write port.
// ----------------------------------------------------------------------------
module bfpa_table
    import bfpa_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
    localparam int unsigned IdxBits      = $clog2(TABLE_ENTRIES),
    localparam int unsigned WordBits     = 2 * AddrBits + 2
) (
    input  logic                aclk,
    input  logic [IdxBits-1:0]  rd_idx,
    output logic [WordBits-1:0] rd_data,
    input  logic                wr_en,
    input  logic [IdxBits-1:0]  wr_idx,
    input  logic [WordBits-1:0] wr_data
);

    logic [WordBits-1:0] mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

[rtl/best_fit_pool_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_pool_allocator
// Best-fit allocator over a byte pool with a block table and splitting.
// ----------------------------------------------------------------------------
// Each request walks the whole block table in memory, one entry a cycle; an
// allocate of zero bytes or of a rounded size above 32 bits skips the walk
// and is answered directly. After reset and after every pool_bytes write the
// table is swept clear, and no request is taken during the sweep. Status 1
// means no block fits, 2 a free of an address that holds no live block;
// every result carries the allocation statistics.
module best_fit_pool_allocator
    import bfpa_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[0], request_size[32:1], align_log2[36:33], block_address[68:37]
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], address[33:2], alloc_total[65:34],
    // live_allocations[72:66], free_block_count[79:73]
    output logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned IdxBits  = $clog2(TABLE_ENTRIES);
    localparam int unsigned WordBits = 2 * AddrBits + 2;
    localparam int unsigned CntBits  = IdxBits + 1;

    state_t state_reg, state_next;

    logic [31:0] pool_reg;
    logic [15:0] thr_reg;
    logic        cfg_wr;
    logic        pool_wr;

    logic               act_reg;
    logic [32:0]        need_reg;
    logic [31:0]        where_reg;
    logic [IdxBits:0]   cnt_reg;
    logic [IdxBits-1:0] ridx_reg;
    logic               found_reg;
    logic [IdxBits-1:0] best_reg;
    logic [31:0]        bsize_reg, bstart_reg;
    logic               spare_ok_reg;
    logic [IdxBits-1:0] spare_reg;
    logic [31:0]        bytes_reg;
    logic [CntBits-1:0] live_reg, freec_reg;
    logic [1:0]         status_reg;
    logic [31:0]        addr_reg;

    logic [IdxBits-1:0]  rd_idx;
    logic [WordBits-1:0] rd_data;
    logic                wr_en;
    logic [IdxBits-1:0]  wr_idx;
    logic [WordBits-1:0] wr_data;

    logic [AddrBits-1:0] e_start, e_size;
    logic                e_valid, e_use;

    assign e_start = rd_data[AddrBits-1:0];
    assign e_size  = rd_data[2*AddrBits-1:AddrBits];
    assign e_valid = rd_data[2*AddrBits];
    assign e_use   = rd_data[2*AddrBits+1];

    bfpa_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .aclk    (aclk),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign pool_wr = cfg_wr && (paddr[2:2] == RegPoolBytes[0:0]);

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == RegSplitThres[0]) begin
            prdata = {16'd0, thr_reg};
        end else begin
            prdata = pool_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= PoolBytesReset;
            thr_reg  <= SplitThreshReset;
        end else if (cfg_wr) begin
            if (paddr[2] == RegPoolBytes[0]) begin
                pool_reg <= pwdata;
            end else begin
                thr_reg <= pwdata[15:0];
            end
        end
    end

    // rounded request size
    logic [32:0] unit_m1, need_c;
    always_comb begin
        unit_m1 = (33'd1 << s_tdata[36:33]) - 33'd1;
        need_c  = ({1'b0, s_tdata[32:1]} + unit_m1) & ~unit_m1;
    end

    // entry of the current scan step
    logic [IdxBits-1:0] scan_idx;
    logic               fit_c, better_c, hit_c;
    assign scan_idx = cnt_reg[IdxBits-1:0] - IdxBits'(1);
    always_comb begin
        fit_c    = e_valid && !e_use && ({1'b0, 32'(e_size)} >= need_reg);
        better_c = !found_reg || (32'(e_size) < bsize_reg) ||
                   ((32'(e_size) == bsize_reg) && (32'(e_start) < bstart_reg));
        hit_c    = e_valid && e_use && (32'(e_start) == where_reg);
    end

    logic [32:0] left_c;
    logic        split_c;
    assign left_c  = {1'b0, bsize_reg} - need_reg;
    assign split_c = (left_c > {17'd0, thr_reg}) && spare_ok_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0] == ActionAlloc &&
                        (need_c == 33'd0 || need_c[32])) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg == (IdxBits+1)'(TABLE_ENTRIES - 1)) state_next = ST_LAST;
            end
            ST_LAST:   state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_SPLIT;
            ST_SPLIT:  state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            ST_CLEAR:  if (cnt_reg == (IdxBits+1)'(TABLE_ENTRIES - 1)) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        if (pool_wr) begin
            state_next = ST_CLEAR;
        end
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE) && !pool_wr;
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {7'(freec_reg), 7'(live_reg), bytes_reg, addr_reg, status_reg};
        rd_idx   = ridx_reg;
        wr_en    = 1'b0;
        wr_idx   = best_reg;
        wr_data  = '0;
        case (state_reg)
            ST_IDLE: begin
                rd_idx = '0;
            end
            ST_CLEAR: begin
                wr_en  = 1'b1;
                wr_idx = cnt_reg[IdxBits-1:0];
                if (cnt_reg == '0) begin
                    wr_data = {1'b0, 1'b1, AddrBits'(pool_reg), {AddrBits{1'b0}}};
                end
            end
            ST_COMMIT: begin
                if (found_reg) begin
                    wr_en = 1'b1;
                    if (act_reg == ActionFree) begin
                        wr_data = {1'b0, 1'b1, AddrBits'(bsize_reg), AddrBits'(bstart_reg)};
                    end else if (split_c) begin
                        wr_data = {1'b1, 1'b1, AddrBits'(need_reg), AddrBits'(bstart_reg)};
                    end else begin
                        wr_data = {1'b1, 1'b1, AddrBits'(bsize_reg), AddrBits'(bstart_reg)};
                    end
                end
            end
            ST_SPLIT: begin
                if (found_reg && act_reg == ActionAlloc && split_c) begin
                    wr_en   = 1'b1;
                    wr_idx  = spare_reg;
                    wr_data = {1'b0, 1'b1, AddrBits'(left_c[31:0]),
                               AddrBits'(bstart_reg + need_reg[31:0])};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            bytes_reg <= '0;
            live_reg  <= '0;
            freec_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pool_wr) begin
                cnt_reg <= '0;
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        act_reg      <= s_tdata[0];
                        need_reg     <= need_c;
                        where_reg    <= s_tdata[68:37];
                        cnt_reg      <= (IdxBits+1)'(1);
                        ridx_reg     <= IdxBits'(1);
                        found_reg    <= 1'b0;
                        spare_ok_reg <= 1'b0;
                        status_reg   <= StatusNoFit;
                        addr_reg     <= '0;
                        if (s_tvalid && state_next == ST_SCAN) begin
                            live_reg  <= '0;
                            freec_reg <= '0;
                        end
                    end
                    ST_SCAN, ST_LAST: begin
                        if (state_reg == ST_SCAN) begin
                            cnt_reg  <= cnt_reg + 1'b1;
                            ridx_reg <= ridx_reg + 1'b1;
                        end
                        if (e_valid && e_use) live_reg <= live_reg + 1'b1;
                        if (e_valid && !e_use) freec_reg <= freec_reg + 1'b1;
                        if (!e_valid && !spare_ok_reg) begin
                            spare_ok_reg <= 1'b1;
                            spare_reg    <= scan_idx;
                        end
                        if (act_reg == ActionAlloc) begin
                            if (fit_c && better_c) begin
                                found_reg  <= 1'b1;
                                best_reg   <= scan_idx;
                                bsize_reg  <= 32'(e_size);
                                bstart_reg <= 32'(e_start);
                            end
                        end else if (hit_c && !found_reg) begin
                            found_reg  <= 1'b1;
                            best_reg   <= scan_idx;
                            bsize_reg  <= 32'(e_size);
                            bstart_reg <= 32'(e_start);
                        end
                    end
                    ST_COMMIT: begin
                        if (act_reg == ActionFree) begin
                            status_reg <= found_reg ? StatusOk : StatusBadFree;
                            if (found_reg) begin
                                bytes_reg <= bytes_reg - bsize_reg;
                                live_reg  <= live_reg - 1'b1;
                                freec_reg <= freec_reg + 1'b1;
                            end
                        end else if (found_reg) begin
                            status_reg <= StatusOk;
                            addr_reg   <= bstart_reg;
                            live_reg   <= live_reg + 1'b1;
                            if (split_c) begin
                                bytes_reg <= bytes_reg + need_reg[31:0];
                            end else begin
                                bytes_reg <= bytes_reg + bsize_reg;
                                freec_reg <= freec_reg - 1'b1;
                            end
                        end
                    end
                    ST_CLEAR: begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        bytes_reg <= '0;
                        live_reg  <= '0;
                        freec_reg <= CntBits'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // scan must start by reading entry zero; issue it from idle
    // (ridx_reg advances one ahead of the compare)

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before transfer");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_ok_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg != StatusOk) |-> (addr_reg == 32'd0))
        else $error("address set on failed request");
`endif

endmodule

[sim/tb_best_fit_pool_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_pool_allocator
// Self-checking testbench for the best-fit pool allocator.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the block table and predicts status,
// address and statistics for every accepted request. A short directed part
// covers the edge cases: zero size, rounding overflow, alignments above 12,
// bad and double frees, and zero and full-range pool sizes. Random sessions
// follow under changing pool and split settings. These sessions mostly
// allocate and free live blocks, and add some noise and some table-fill
// runs. Both stream sides stall at random, and the result side at times
// holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_best_fit_pool_allocator;
    import bfpa_pkg::*;

    localparam int  Entries    = 64;
    localparam int  ItemTarget = 800;
    localparam int  CycleLimit = 3000000;
    localparam int  HoldCycles = 400;

    class alloc_scoreboard;
        logic [31:0] pool_total;
        logic [15:0] split_min;
        logic [31:0] blk_start [Entries];
        logic [31:0] blk_size  [Entries];
        bit          blk_valid [Entries];
        bit          blk_used  [Entries];
        logic [31:0] bytes_used;
        logic [79:0] expected_q [$];
        int          errors;
        int          n_ok;
        int          n_nofit;
        int          n_badfree;

        function void clear_table();
            for (int i = 0; i < Entries; i++) begin
                blk_start[i] = '0;
                blk_size[i]  = '0;
                blk_valid[i] = 0;
                blk_used[i]  = 0;
            end
            blk_size[0]  = pool_total;
            blk_valid[0] = 1;
            bytes_used   = '0;
        endfunction

        function void power_on();
            pool_total = PoolBytesReset;
            split_min = SplitThreshReset;
            errors = 0;
            clear_table();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == RegPoolBytes) begin
                pool_total = val;
                clear_table();
            end else if (idx == RegSplitThres) begin
                split_min = val[15:0];
            end
        endfunction

        function logic [1:0] try_alloc(logic [31:0] req, logic [3:0] lg,
                                       output logic [31:0] got);
            logic [63:0] unit;
            logic [63:0] need;
            logic [63:0] left;
            int best;
            int spare;
            got   = '0;
            best  = -1;
            spare = -1;
            unit  = 64'd1 << lg;
            need  = ({32'd0, req} + unit - 1) & ~(unit - 1);
            if (need == 0 || need > 64'hFFFF_FFFF) return StatusNoFit;
            for (int i = 0; i < Entries; i++) begin
                if (!blk_valid[i]) begin
                    if (spare < 0) spare = i;
                end else if (!blk_used[i] && {32'd0, blk_size[i]} >= need) begin
                    if (best < 0 || blk_size[i] < blk_size[best] ||
                        (blk_size[i] == blk_size[best] && blk_start[i] < blk_start[best]))
                        best = i;
                end
            end
            if (best < 0) return StatusNoFit;
            blk_used[best] = 1;
            left = {32'd0, blk_size[best]} - need;
            if (left > {48'd0, split_min} && spare >= 0) begin
                blk_start[spare] = blk_start[best] + need[31:0];
                blk_size[spare]  = left[31:0];
                blk_valid[spare] = 1;
                blk_used[spare]  = 0;
                blk_size[best]   = need[31:0];
            end
            bytes_used = bytes_used + blk_size[best];
            got = blk_start[best];
            return StatusOk;
        endfunction

        function logic [1:0] try_free(logic [31:0] where);
            for (int i = 0; i < Entries; i++) begin
                if (blk_valid[i] && blk_used[i] && blk_start[i] == where) begin
                    blk_used[i] = 0;
                    bytes_used  = bytes_used - blk_size[i];
                    return StatusOk;
                end
            end
            return StatusBadFree;
        endfunction

        function void note_request(logic [71:0] d);
            logic [1:0]  st;
            logic [31:0] addr;
            logic [6:0]  live;
            logic [6:0]  freec;
            addr = '0;
            if (d[0] == ActionAlloc) st = try_alloc(d[32:1], d[36:33], addr);
            else                     st = try_free(d[68:37]);
            live  = '0;
            freec = '0;
            for (int i = 0; i < Entries; i++) begin
                if (blk_valid[i]) begin
                    if (blk_used[i]) live++;
                    else             freec++;
                end
            end
            if (st != StatusOk) addr = '0;
            case (st)
                StatusOk:    n_ok++;
                StatusNoFit: n_nofit++;
                default:     n_badfree++;
            endcase
            expected_q.push_back({freec, live, bytes_used, addr, st});
        endfunction

        function void check_result(logic [79:0] r);
            logic [79:0] e;
            if (expected_q.size() == 0) begin
                $error("result transfer with no request pending: %h", r);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r[1:0] !== e[1:0]) begin
                $error("status: expected %0d, got %0d", e[1:0], r[1:0]);
                errors++;
            end
            if (r[33:2] !== e[33:2]) begin
                $error("address: expected %h, got %h", e[33:2], r[33:2]);
                errors++;
            end
            if (r[65:34] !== e[65:34]) begin
                $error("alloc_total: expected %h, got %h", e[65:34], r[65:34]);
                errors++;
            end
            if (r[72:66] !== e[72:66]) begin
                $error("live_allocations: expected %0d, got %0d", e[72:66], r[72:66]);
                errors++;
            end
            if (r[79:73] !== e[79:73]) begin
                $error("free_block_count: expected %0d, got %0d", e[79:73], r[79:73]);
                errors++;
            end
        endfunction

        function logic [31:0] pick_live();
            int idx [$];
            for (int i = 0; i < Entries; i++)
                if (blk_valid[i] && blk_used[i]) idx.push_back(i);
            if (idx.size() == 0) return $urandom;
            return blk_start[idx[$urandom_range(idx.size() - 1)]];
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // action, request_size, align_log2, block_address
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // status, address, alloc_total, live_allocations, free_block_count
    logic [79:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb;
    int  cycles;
    int  sent;
    int  hold_left;
    bit  hold_req;
    bit  quiet;
    int  settings_used;

    best_fit_pool_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side readiness
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_item(input logic [71:0] d);
        if (!quiet && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(d);
        sent++;
    endtask

    task automatic send_alloc(input logic [31:0] req, input logic [3:0] lg);
        logic [31:0] junk;
        junk = $urandom;
        send_item({3'd0, junk, lg, req, ActionAlloc});
    endtask

    task automatic send_free(input logic [31:0] where);
        logic [31:0] junk;
        junk = $urandom;
        send_item({3'd0, where, 4'($urandom), junk, ActionFree});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        settings_used++;
    endtask

    task automatic random_session(input int count, input bit fill);
        logic [31:0] req;
        for (int k = 0; k < count; k++) begin
            if (fill) begin
                send_alloc($urandom_range(1, 16), 4'($urandom_range(0, 4)));
            end else if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 45 && sb.pick_live() !== 'x &&
                    sb.bytes_used != 0) begin
                    send_free(sb.pick_live());
                end else begin
                    req = ($urandom_range(9) == 0) ? 32'($urandom)
                                                   : 32'($urandom_range(1, 3000));
                    send_alloc(req, ($urandom_range(3) == 0) ? 4'($urandom)
                                                             : 4'($urandom_range(0, 12)));
                end
            end else if ($urandom_range(1) == 0) begin
                send_free($urandom);
            end else begin
                send_alloc($urandom, 4'($urandom));
            end
        end
    endtask

    initial begin
        logic [31:0] p;
        sb = new();
        sb.power_on();
        cycles = 0;
        sent = 0;
        hold_left = 0;
        hold_req = 0;
        quiet = 0;
        settings_used = 0;
        m_tready = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed edge cases, starting at reset settings
        send_alloc(32'd0, 4'd0);
        send_alloc(32'hFFFF_FFFF, 4'd0);
        send_alloc(32'hFFFF_FFFF, 4'd15);
        send_alloc(32'd100, 4'd15);
        send_alloc(32'd1, 4'd0);
        send_alloc(32'd5, 4'd12);
        send_alloc(32'd1000, 4'd3);
        send_free(32'd0);
        send_free(32'd0);
        send_free(32'hFFFF_FFFF);
        send_alloc(32'd1048576, 4'd0);
        send_free(sb.pick_live());
        apb_write(RegPoolBytes, 32'd0);
        send_alloc(32'd1, 4'd0);
        send_free(32'd0);
        apb_write(RegPoolBytes, 32'hFFFF_FFFF);
        apb_write(RegSplitThres, 32'd65535);
        send_alloc(32'hFFFF_FFFF, 4'd0);
        send_free(32'd0);
        send_alloc(32'h8000_0000, 4'd15);
        send_alloc(32'd70000, 4'd1);

        // table fill with no split threshold, result side held off at first
        apb_write(RegPoolBytes, 32'd4096);
        apb_write(RegSplitThres, 32'd0);
        hold_req = 1;
        random_session(70, 1);
        random_session(30, 0);

        while (sent < ItemTarget) begin
            case ($urandom_range(4))
                0:       p = 32'd1;
                1:       p = 32'hFFFF_FFFF;
                2:       p = $urandom;
                default: p = $urandom_range(256, 65536);
            endcase
            apb_write(RegPoolBytes, p);
            case ($urandom_range(3))
                0:       apb_write(RegSplitThres, 32'd0);
                1:       apb_write(RegSplitThres, 32'd65535);
                default: apb_write(RegSplitThres, $urandom_range(0, 512));
            endcase
            quiet = ($urandom_range(5) == 0);
            if ($urandom_range(4) == 0) hold_req = 1;
            random_session($urandom_range(20, 60), $urandom_range(6) == 0);
            if ($urandom_range(2) == 0) begin
                drain();
                random_session(10, 0);
            end
        end
        quiet = 0;

        drain();
        repeat (200) @(posedge aclk);
        $display("%0d requests over %0d register writes: %0d ok, %0d no fit, %0d bad free",
                 sent, settings_used, sb.n_ok, sb.n_nofit, sb.n_badfree);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
